>>> rtl/core/utf8xv_pkg.sv
// package with codes, constants and character checks for the utf-8 xml validator
`timescale 1ns / 1ps
`default_nettype none

package utf8xv_pkg;

    // width of the position fields on the result channel
    localparam int unsigned OUT_POS_W = 32;

    // width of an assembled code point
    localparam int unsigned CP_W = 21;

    // request operation codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // latched error kinds
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_XML_CHAR = 2'd1,
        ERR_UTF8     = 2'd2
    } err_kind_t;

    // minimum code point class of a multibyte sequence
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_MIN2  = 2'd1,
        CLS_MIN3  = 2'd2,
        CLS_MIN4  = 2'd3
    } min_class_t;

    // lead byte ranges
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] LF_BYTE   = 8'h0A;

    // code point limits
    localparam logic [CP_W-1:0] CP_TAB       = 21'h00009;
    localparam logic [CP_W-1:0] CP_LF        = 21'h0000A;
    localparam logic [CP_W-1:0] CP_CR        = 21'h0000D;
    localparam logic [CP_W-1:0] CP_SPACE     = 21'h00020;
    localparam logic [CP_W-1:0] CP_BMP_LO_MAX = 21'h0D7FF;
    localparam logic [CP_W-1:0] CP_BMP_HI_MIN = 21'h0E000;
    localparam logic [CP_W-1:0] CP_BMP_HI_MAX = 21'h0FFFD;
    localparam logic [CP_W-1:0] CP_SUPP_MIN  = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_MIN2      = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN3      = 21'h00800;

    // legal xml character test
    function automatic logic xml_allowed(input logic [CP_W-1:0] cp);
        return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
               ((cp >= CP_SPACE) && (cp <= CP_BMP_LO_MAX)) ||
               ((cp >= CP_BMP_HI_MIN) && (cp <= CP_BMP_HI_MAX)) ||
               ((cp >= CP_SUPP_MIN) && (cp <= CP_MAX));
    endfunction

    // smallest code point a sequence class may encode
    function automatic logic [CP_W-1:0] class_minimum(input min_class_t cls);
        logic [CP_W-1:0] m;
        case (cls)
            CLS_MIN2: m = CP_MIN2;
            CLS_MIN3: m = CP_MIN3;
            CLS_MIN4: m = CP_SUPP_MIN;
            default:  m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/utf8_xml_char_validator.sv
// utf-8 stream validator restricted to legal xml characters, with position tracking
//
//  channel | direction | fields                                          | handshake
//  s_      | in        | operation, data_byte                            | s_valid / s_ready
//  m_      | out       | error_kind, fault_line, fault_column,           | m_valid / m_ready
//          |           | line_now, column_now, sequence_pending          |
//
// one request per cycle while m_ready is high; path: input register, then result register
// the byte checks, code point assembly and position counters sit between those two registers
// aresetn is synchronous: position returns to line 1 column 1 and the error latch clears
// a stalled result register holds the one request already in the input register and
// lowers s_ready until m_ready frees it
`timescale 1ns / 1ps
`default_nettype none

module utf8_xml_char_validator #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_data_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_error_kind,
    output logic [31:0]      m_fault_line,
    output logic [31:0]      m_fault_column,
    output logic [31:0]      m_line_now,
    output logic [31:0]      m_column_now,
    output logic             m_sequence_pending
);

    localparam int unsigned PW    = POSITION_WIDTH;
    localparam int unsigned OW    = utf8xv_pkg::OUT_POS_W;
    localparam int unsigned EXT_W = (PW > OW) ? PW : OW;
    localparam int unsigned CPW   = utf8xv_pkg::CP_W;

    // input register
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;

    // validator state
    logic [PW-1:0]           line_reg, line_next;
    logic [PW-1:0]           col_reg, col_next;
    logic [CPW-1:0]          cp_reg, cp_next;
    utf8xv_pkg::min_class_t  cls_reg, cls_next;
    logic [1:0]              rem_reg, rem_next;
    logic [PW-1:0]           seq_line_reg, seq_line_next;
    logic [PW-1:0]           seq_col_reg, seq_col_next;
    utf8xv_pkg::err_kind_t   err_reg, err_next;
    logic [PW-1:0]           err_line_reg, err_line_next;
    logic [PW-1:0]           err_col_reg, err_col_next;

    // result register
    logic        m_valid_reg;
    logic [1:0]  res_kind_reg;
    logic [31:0] res_err_line_reg;
    logic [31:0] res_err_col_reg;
    logic [31:0] res_line_reg;
    logic [31:0] res_col_reg;
    logic        res_pend_reg;

    logic            advance;
    logic [CPW-1:0]  cp_asm;
    logic [PW-1:0]   line_inc;
    logic [PW-1:0]   col_inc;
    logic [EXT_W-1:0] err_line_ext, err_col_ext, line_ext, col_ext;

    // handshake
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // code point with the continuation bits shifted in
    assign cp_asm = {cp_reg[CPW-7:0], in_byte_reg[5:0]};

    // saturating position increments
    assign line_inc = (line_reg == {PW{1'b1}}) ? line_reg : line_reg + 1'b1;
    assign col_inc  = (col_reg == {PW{1'b1}}) ? col_reg : col_reg + 1'b1;

    // next state for one request
    always_comb begin
        line_next     = line_reg;
        col_next      = col_reg;
        cp_next       = cp_reg;
        cls_next      = cls_reg;
        rem_next      = rem_reg;
        seq_line_next = seq_line_reg;
        seq_col_next  = seq_col_reg;
        err_next      = err_reg;
        err_line_next = err_line_reg;
        err_col_next  = err_col_reg;

        if (advance) begin
            if (in_op_reg == utf8xv_pkg::OP_DATA) begin
                if (err_reg == utf8xv_pkg::ERR_NONE) begin
                    if (rem_reg == 2'd0) begin
                        if (!in_byte_reg[7]) begin
                            if (!utf8xv_pkg::xml_allowed(CPW'(in_byte_reg))) begin
                                err_next      = utf8xv_pkg::ERR_XML_CHAR;
                                err_line_next = line_reg;
                                err_col_next  = col_reg;
                            end
                        end else begin
                            seq_line_next = line_reg;
                            seq_col_next  = col_reg;
                            if (in_byte_reg >= utf8xv_pkg::LEAD2_MIN &&
                                in_byte_reg <= utf8xv_pkg::LEAD2_MAX) begin
                                cp_next  = CPW'(in_byte_reg[4:0]);
                                cls_next = utf8xv_pkg::CLS_MIN2;
                                rem_next = 2'd1;
                            end else if (in_byte_reg >= utf8xv_pkg::LEAD3_MIN &&
                                         in_byte_reg <= utf8xv_pkg::LEAD3_MAX) begin
                                cp_next  = CPW'(in_byte_reg[3:0]);
                                cls_next = utf8xv_pkg::CLS_MIN3;
                                rem_next = 2'd2;
                            end else if (in_byte_reg >= utf8xv_pkg::LEAD4_MIN &&
                                         in_byte_reg <= utf8xv_pkg::LEAD4_MAX) begin
                                cp_next  = CPW'(in_byte_reg[2:0]);
                                cls_next = utf8xv_pkg::CLS_MIN4;
                                rem_next = 2'd3;
                            end else begin
                                err_next      = utf8xv_pkg::ERR_UTF8;
                                err_line_next = line_reg;
                                err_col_next  = col_reg;
                            end
                        end
                    end else if (in_byte_reg[7:6] != 2'b10) begin
                        // not a continuation byte, sequence state kept
                        err_next      = utf8xv_pkg::ERR_UTF8;
                        err_line_next = seq_line_reg;
                        err_col_next  = seq_col_reg;
                    end else begin
                        cp_next  = cp_asm;
                        rem_next = rem_reg - 2'd1;
                        // last byte: overlong, surrogate, range and xml checks
                        if (rem_reg == 2'd1 &&
                            (cp_asm < utf8xv_pkg::class_minimum(cls_reg) ||
                             !utf8xv_pkg::xml_allowed(cp_asm))) begin
                            err_next      = utf8xv_pkg::ERR_UTF8;
                            err_line_next = seq_line_reg;
                            err_col_next  = seq_col_reg;
                        end
                    end
                end

                // position moves for every data byte
                if (in_byte_reg == utf8xv_pkg::LF_BYTE) begin
                    line_next = line_inc;
                    col_next  = PW'(1);
                end else begin
                    col_next = col_inc;
                end
            end else begin
                // end of input: flag a truncated sequence
                if (rem_reg != 2'd0 && err_reg == utf8xv_pkg::ERR_NONE) begin
                    err_next      = utf8xv_pkg::ERR_UTF8;
                    err_line_next = seq_line_reg;
                    err_col_next  = seq_col_reg;
                end
                rem_next = 2'd0;
            end
        end
    end

    // positions brought to the result width
    assign err_line_ext = EXT_W'(err_line_next);
    assign err_col_ext  = EXT_W'(err_col_next);
    assign line_ext     = EXT_W'(line_next);
    assign col_ext      = EXT_W'(col_next);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_byte_reg <= s_data_byte;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg     <= PW'(1);
            col_reg      <= PW'(1);
            cp_reg       <= '0;
            cls_reg      <= utf8xv_pkg::CLS_NONE;
            rem_reg      <= 2'd0;
            seq_line_reg <= '0;
            seq_col_reg  <= '0;
            err_reg      <= utf8xv_pkg::ERR_NONE;
            err_line_reg <= '0;
            err_col_reg  <= '0;
        end else begin
            line_reg     <= line_next;
            col_reg      <= col_next;
            cp_reg       <= cp_next;
            cls_reg      <= cls_next;
            rem_reg      <= rem_next;
            seq_line_reg <= seq_line_next;
            seq_col_reg  <= seq_col_next;
            err_reg      <= err_next;
            err_line_reg <= err_line_next;
            err_col_reg  <= err_col_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            res_kind_reg     <= err_next;
            res_err_line_reg <= err_line_ext[OW-1:0];
            res_err_col_reg  <= err_col_ext[OW-1:0];
            res_line_reg     <= line_ext[OW-1:0];
            res_col_reg      <= col_ext[OW-1:0];
            res_pend_reg     <= (rem_next != 2'd0);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_error_kind       = res_kind_reg;
    assign m_fault_line       = res_err_line_reg;
    assign m_fault_column     = res_err_col_reg;
    assign m_line_now         = res_line_reg;
    assign m_column_now       = res_col_reg;
    assign m_sequence_pending = res_pend_reg;

`ifndef ASSERT_OFF
    // first error never changes once latched
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != utf8xv_pkg::ERR_NONE) |=>
            (err_reg == $past(err_reg) && err_line_reg == $past(err_line_reg) &&
             err_col_reg == $past(err_col_reg)))
        else $error("latched error changed");

    // a latched error always carries a real line
    a_err_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != utf8xv_pkg::ERR_NONE) |-> (err_line_reg != '0))
        else $error("error latched without a line");

    // line and column count from one and never wrap to zero
    a_col_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg != '0) && (line_reg != '0))
        else $error("position counter reached zero");

    // end of input always clears a pending sequence
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == utf8xv_pkg::OP_END) |=> (rem_reg == 2'd0))
        else $error("sequence still pending after end of input");
`endif

endmodule

`default_nettype wire

>>> tb/utf8_xml_char_validator_tb.sv
// self-checking testbench for the utf-8 xml character validator
`timescale 1ns / 1ps

module utf8_xml_char_validator_tb;

    localparam int CYCLE_LIMIT = 100000;
    localparam int BODY_BYTES  = 1000;
    localparam int NOISE_ITEMS = 140;
    localparam int TAIL_ITEMS  = 150;
    localparam int DRAIN_WAIT  = 8;
    localparam int CP_W        = utf8xv_pkg::CP_W;

    // one request for the input channel, or a marker that holds the sender until drained
    typedef struct {
        logic       op;
        logic [7:0] data;
        bit         drain;
    } byte_req_t;

    // status report the block returns for every request
    typedef struct {
        utf8xv_pkg::err_kind_t kind;
        logic [31:0]           err_line;
        logic [31:0]           err_col;
        logic [31:0]           line;
        logic [31:0]           col;
        logic                  pending;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = utf8xv_pkg::OP_DATA;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_error_kind;
    logic [31:0] m_fault_line;
    logic [31:0] m_fault_column;
    logic [31:0] m_line_now;
    logic [31:0] m_column_now;
    logic        m_sequence_pending;

    byte_req_t byte_q[$];
    status_t   status_q[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  send_calm = 0;
    int  stall_left = 0;
    int  recv_calm = 0;
    bit  quiet_tail = 1'b0;
    byte_req_t next_req;
    status_t   due;

    // shadow of the validator state
    logic [31:0]            line_pos;
    logic [31:0]            col_pos;
    logic [CP_W-1:0]        cp_acc;
    utf8xv_pkg::min_class_t cp_class;
    logic [1:0]             cont_left;
    logic [31:0]            seq_line;
    logic [31:0]            seq_col;
    utf8xv_pkg::err_kind_t  err_kind;
    logic [31:0]            err_line;
    logic [31:0]            err_col;

    always #4 aclk = ~aclk;

    utf8_xml_char_validator dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_error_kind       (m_error_kind),
        .m_fault_line       (m_fault_line),
        .m_fault_column     (m_fault_column),
        .m_line_now         (m_line_now),
        .m_column_now       (m_column_now),
        .m_sequence_pending (m_sequence_pending)
    );

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic bit xml_char_ok(input logic [CP_W-1:0] cp);
        if (cp > utf8xv_pkg::CP_MAX)
            return 1'b0;
        if (cp < utf8xv_pkg::CP_SPACE)
            return (cp == utf8xv_pkg::CP_TAB) || (cp == utf8xv_pkg::CP_LF) ||
                   (cp == utf8xv_pkg::CP_CR);
        if ((cp > utf8xv_pkg::CP_BMP_LO_MAX) && (cp < utf8xv_pkg::CP_BMP_HI_MIN))
            return 1'b0;
        if ((cp > utf8xv_pkg::CP_BMP_HI_MAX) && (cp < utf8xv_pkg::CP_SUPP_MIN))
            return 1'b0;
        return 1'b1;
    endfunction

    // only the first error sticks
    function automatic void latch_first(input utf8xv_pkg::err_kind_t k,
                                        input logic [31:0] ln, input logic [31:0] cn);
        if (err_kind == utf8xv_pkg::ERR_NONE) begin
            err_kind = k;
            err_line = ln;
            err_col  = cn;
        end
    endfunction

    // advance the shadow state by one request and return the status it should produce
    function automatic status_t track_byte(input logic op, input logic [7:0] b);
        status_t         r;
        logic [CP_W-1:0] floor_cp;
        if (op == utf8xv_pkg::OP_DATA) begin
            if (err_kind == utf8xv_pkg::ERR_NONE) begin
                if (cont_left == 2'd0) begin
                    if (b < 8'h80) begin
                        if (!xml_char_ok({13'd0, b}))
                            latch_first(utf8xv_pkg::ERR_XML_CHAR, line_pos, col_pos);
                    end else begin
                        seq_line = line_pos;
                        seq_col  = col_pos;
                        if (b >= utf8xv_pkg::LEAD2_MIN &&
                            b <= utf8xv_pkg::LEAD2_MAX) begin
                            cp_acc    = {16'd0, b[4:0]};
                            cp_class  = utf8xv_pkg::CLS_MIN2;
                            cont_left = 2'd1;
                        end else if (b >= utf8xv_pkg::LEAD3_MIN &&
                                     b <= utf8xv_pkg::LEAD3_MAX) begin
                            cp_acc    = {17'd0, b[3:0]};
                            cp_class  = utf8xv_pkg::CLS_MIN3;
                            cont_left = 2'd2;
                        end else if (b >= utf8xv_pkg::LEAD4_MIN &&
                                     b <= utf8xv_pkg::LEAD4_MAX) begin
                            cp_acc    = {18'd0, b[2:0]};
                            cp_class  = utf8xv_pkg::CLS_MIN4;
                            cont_left = 2'd3;
                        end else begin
                            latch_first(utf8xv_pkg::ERR_UTF8, line_pos, col_pos);
                        end
                    end
                end else if (b[7:6] != 2'b10) begin
                    // broken sequence: blame its first byte, keep the sequence state
                    latch_first(utf8xv_pkg::ERR_UTF8, seq_line, seq_col);
                end else begin
                    cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    case (cp_class)
                        utf8xv_pkg::CLS_MIN2: floor_cp = utf8xv_pkg::CP_MIN2;
                        utf8xv_pkg::CLS_MIN3: floor_cp = utf8xv_pkg::CP_MIN3;
                        utf8xv_pkg::CLS_MIN4: floor_cp = utf8xv_pkg::CP_SUPP_MIN;
                        default:              floor_cp = '0;
                    endcase
                    if (cont_left == 2'd0 && (cp_acc < floor_cp || !xml_char_ok(cp_acc)))
                        latch_first(utf8xv_pkg::ERR_UTF8, seq_line, seq_col);
                end
            end
            if (b == utf8xv_pkg::LF_BYTE) begin
                line_pos = sat_inc(line_pos);
                col_pos  = 32'd1;
            end else begin
                col_pos = sat_inc(col_pos);
            end
        end else begin
            // end of input: an unfinished sequence is an error
            if (cont_left != 2'd0)
                latch_first(utf8xv_pkg::ERR_UTF8, seq_line, seq_col);
            cont_left = 2'd0;
        end
        r.kind     = err_kind;
        r.err_line = err_line;
        r.err_col  = err_col;
        r.line     = line_pos;
        r.col      = col_pos;
        r.pending  = (cont_left != 2'd0);
        return r;
    endfunction

    task automatic push_req(input logic op, input logic [7:0] data);
        byte_req_t r;
        r.op    = op;
        r.data  = data;
        r.drain = 1'b0;
        byte_q.push_back(r);
    endtask

    // utf-8 encode one code point into data requests
    task automatic push_cp(input logic [CP_W-1:0] cp);
        if (cp < utf8xv_pkg::CP_MIN2) begin
            push_req(utf8xv_pkg::OP_DATA, cp[7:0]);
        end else if (cp < utf8xv_pkg::CP_MIN3) begin
            push_req(utf8xv_pkg::OP_DATA, {3'b110, cp[10:6]});
            push_req(utf8xv_pkg::OP_DATA, {2'b10, cp[5:0]});
        end else if (cp < utf8xv_pkg::CP_SUPP_MIN) begin
            push_req(utf8xv_pkg::OP_DATA, {4'b1110, cp[15:12]});
            push_req(utf8xv_pkg::OP_DATA, {2'b10, cp[11:6]});
            push_req(utf8xv_pkg::OP_DATA, {2'b10, cp[5:0]});
        end else begin
            push_req(utf8xv_pkg::OP_DATA, {5'b11110, cp[20:18]});
            push_req(utf8xv_pkg::OP_DATA, {2'b10, cp[17:12]});
            push_req(utf8xv_pkg::OP_DATA, {2'b10, cp[11:6]});
            push_req(utf8xv_pkg::OP_DATA, {2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // stimulus and end of run
    initial begin
        byte_req_t  hold;
        logic [7:0] bad;
        bit         drain_done;
        drain_done = 1'b0;

        // directed: legal extremes, end with nothing pending
        push_req(utf8xv_pkg::OP_DATA, 8'h09);
        push_req(utf8xv_pkg::OP_DATA, 8'h0A);
        push_req(utf8xv_pkg::OP_DATA, 8'h0D);
        push_req(utf8xv_pkg::OP_DATA, 8'h20);
        push_req(utf8xv_pkg::OP_DATA, 8'h7F);
        push_req(utf8xv_pkg::OP_END, 8'hFF);
        push_req(utf8xv_pkg::OP_END, 8'h00);
        push_cp(21'h00080);
        push_cp(21'h0D7FF);
        push_cp(21'h0FFFD);
        push_cp(21'h10000);
        push_cp(21'h10FFFF);

        // well-formed text with random content
        while (byte_q.size() < BODY_BYTES) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: push_cp(CP_W'($urandom_range(8'h20, 8'h7F)));
                7: begin
                    case ($urandom_range(0, 2))
                        0: push_cp(utf8xv_pkg::CP_TAB);
                        1: push_cp(utf8xv_pkg::CP_CR);
                        default: push_cp(utf8xv_pkg::CP_LF);
                    endcase
                end
                8, 9: push_req(utf8xv_pkg::OP_DATA, utf8xv_pkg::LF_BYTE);
                10, 11, 12: push_cp(CP_W'($urandom_range(utf8xv_pkg::CP_MIN2,
                                                          utf8xv_pkg::CP_MIN3 - 1)));
                13, 14, 15: begin
                    if ($urandom_range(0, 1))
                        push_cp(CP_W'($urandom_range(utf8xv_pkg::CP_MIN3,
                                                     utf8xv_pkg::CP_BMP_LO_MAX)));
                    else
                        push_cp(CP_W'($urandom_range(utf8xv_pkg::CP_BMP_HI_MIN,
                                                     utf8xv_pkg::CP_BMP_HI_MAX)));
                end
                16, 17: push_cp(CP_W'($urandom_range(utf8xv_pkg::CP_SUPP_MIN,
                                                      utf8xv_pkg::CP_MAX)));
                18: push_req(utf8xv_pkg::OP_END, 8'($urandom_range(0, 255)));
                default: begin
                    case ($urandom_range(0, 7))
                        0: push_cp(utf8xv_pkg::CP_MIN2);
                        1: push_cp(utf8xv_pkg::CP_MIN3 - 1);
                        2: push_cp(utf8xv_pkg::CP_MIN3);
                        3: push_cp(utf8xv_pkg::CP_BMP_LO_MAX);
                        4: push_cp(utf8xv_pkg::CP_BMP_HI_MIN);
                        5: push_cp(utf8xv_pkg::CP_BMP_HI_MAX);
                        6: push_cp(utf8xv_pkg::CP_SUPP_MIN);
                        default: push_cp(utf8xv_pkg::CP_MAX);
                    endcase
                end
            endcase
            // hold the sender once until every status is back
            if (!drain_done && byte_q.size() >= BODY_BYTES / 2) begin
                hold.op    = utf8xv_pkg::OP_DATA;
                hold.data  = 8'h00;
                hold.drain = 1'b1;
                byte_q.push_back(hold);
                drain_done = 1'b1;
            end
        end

        // the error latch never clears and reset comes only once, so each run
        // ends its clean text with one kind of fault picked at random
        case ($urandom_range(0, 7))
            0: begin
                // forbidden control character
                do bad = 8'($urandom_range(0, 31));
                while (bad == 8'h09 || bad == 8'h0A || bad == 8'h0D);
                push_req(utf8xv_pkg::OP_DATA, bad);
            end
            1: begin
                // bad lead byte
                if ($urandom_range(0, 1))
                    push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'hC1)));
                else
                    push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'hF5, 8'hFF)));
            end
            2: begin
                // continuation byte missing
                push_req(utf8xv_pkg::OP_DATA,
                         8'($urandom_range(utf8xv_pkg::LEAD3_MIN + 1, utf8xv_pkg::LEAD3_MAX)));
                push_req(utf8xv_pkg::OP_DATA, rand_cont());
                if ($urandom_range(0, 1))
                    push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'h00, 8'h7F)));
                else
                    push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'hC0, 8'hFF)));
            end
            3: begin
                // overlong form
                if ($urandom_range(0, 1)) begin
                    push_req(utf8xv_pkg::OP_DATA, utf8xv_pkg::LEAD3_MIN);
                    push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'h9F)));
                    push_req(utf8xv_pkg::OP_DATA, rand_cont());
                end else begin
                    push_req(utf8xv_pkg::OP_DATA, utf8xv_pkg::LEAD4_MIN);
                    push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'h8F)));
                    push_req(utf8xv_pkg::OP_DATA, rand_cont());
                    push_req(utf8xv_pkg::OP_DATA, rand_cont());
                end
            end
            4: begin
                // surrogate
                push_req(utf8xv_pkg::OP_DATA, 8'hED);
                push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'hA0, 8'hBF)));
                push_req(utf8xv_pkg::OP_DATA, rand_cont());
            end
            5: begin
                // above the last code point
                push_req(utf8xv_pkg::OP_DATA, utf8xv_pkg::LEAD4_MAX);
                push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'h90, 8'hBF)));
                push_req(utf8xv_pkg::OP_DATA, rand_cont());
                push_req(utf8xv_pkg::OP_DATA, rand_cont());
            end
            6: begin
                // non-character at the top of the basic plane
                push_req(utf8xv_pkg::OP_DATA, utf8xv_pkg::LEAD3_MAX);
                push_req(utf8xv_pkg::OP_DATA, 8'hBF);
                push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(8'hBE, 8'hBF)));
            end
            default: begin
                // input ends inside a sequence
                push_req(utf8xv_pkg::OP_DATA, utf8xv_pkg::LEAD4_MIN);
                push_req(utf8xv_pkg::OP_DATA, 8'h90);
                push_req(utf8xv_pkg::OP_END, 8'($urandom_range(0, 255)));
            end
        endcase

        // noise after the error: position still moves, latch holds
        repeat (NOISE_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                push_req(utf8xv_pkg::OP_END, 8'($urandom_range(0, 255)));
            else
                push_req(utf8xv_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (byte_q.size() != 0 || s_valid);
        while (status_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // request driver and shadow model update
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            line_pos  = 32'd1;
            col_pos   = 32'd1;
            cp_acc    = '0;
            cp_class  = utf8xv_pkg::CLS_NONE;
            cont_left = 2'd0;
            seq_line  = 32'd0;
            seq_col   = 32'd0;
            err_kind  = utf8xv_pkg::ERR_NONE;
            err_line  = 32'd0;
            err_col   = 32'd0;
        end else begin
            if (s_valid && s_ready)
                status_q.push_back(track_byte(s_operation, s_data_byte));
            if (byte_q.size() <= TAIL_ITEMS)
                quiet_tail <= 1'b1;

            if (s_valid && !s_ready) begin
                // request still waiting, hold it
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (byte_q[0].drain) begin
                s_valid <= 1'b0;
                if (status_q.size() == 0)
                    void'(byte_q.pop_front());
            end else if (!quiet_tail && send_calm == 0 && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 8) - 1;
                s_valid <= 1'b0;
            end else begin
                next_req = byte_q.pop_front();
                s_valid     <= 1'b1;
                s_operation <= next_req.op;
                s_data_byte <= next_req.data;
                if (send_calm > 0)
                    send_calm--;
                else if ($urandom_range(0, 40) == 0)
                    send_calm = $urandom_range(20, 80);
            end
        end
    end

    // status monitor and back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("status %0d arrived with no request behind it",
                                              results_seen));
                end else begin
                    due = status_q.pop_front();
                    if (m_error_kind !== due.kind)
                        report_mismatch($sformatf("status %0d error_kind %0d, want %0d",
                                                  results_seen, m_error_kind, due.kind));
                    if (m_fault_line !== due.err_line)
                        report_mismatch($sformatf("status %0d fault_line %0d, want %0d",
                                                  results_seen, m_fault_line, due.err_line));
                    if (m_fault_column !== due.err_col)
                        report_mismatch($sformatf("status %0d fault_column %0d, want %0d",
                                                  results_seen, m_fault_column, due.err_col));
                    if (m_line_now !== due.line)
                        report_mismatch($sformatf("status %0d line_now %0d, want %0d",
                                                  results_seen, m_line_now, due.line));
                    if (m_column_now !== due.col)
                        report_mismatch($sformatf("status %0d column_now %0d, want %0d",
                                                  results_seen, m_column_now, due.col));
                    if (m_sequence_pending !== due.pending)
                        report_mismatch($sformatf("status %0d sequence_pending %0b, want %0b",
                                                  results_seen, m_sequence_pending,
                                                  due.pending));
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 40) == 0)
                    recv_calm = $urandom_range(20, 80);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

>>> utf8_xml_char_validator.f
rtl/core/utf8xv_pkg.sv
rtl/core/utf8_xml_char_validator.sv
tb/utf8_xml_char_validator_tb.sv
